/* src/bpa_pkg.sv */
// Package: shared constants, types and state encoding for the buddy page allocator.
package bpa_pkg;

    localparam int NUM_PAGES_DEF = 1024;
    localparam int ORDERS_DEF    = 8;
    localparam int PW            = 20;
    localparam int CW            = 11;
    localparam int SW            = 3;
    localparam logic [CW-1:0] PAGE_COUNT_RST = 11'd1024;

    typedef enum logic [SW-1:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_BAD_ORDER = 3'd2,
        ST_DBL_FREE  = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    typedef enum logic {
        CFG_BASE_PAGE  = 1'b0,
        CFG_PAGE_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_CK,
        S_A_CLR,
        S_A_SL,
        S_A_SR,
        S_F_RD,
        S_F_CK,
        S_M_TEST,
        S_M_CK,
        S_M_CLRB,
        S_M_PAR,
        S_DONE
    } t_state;

endpackage

/* src/bpa_ram.sv */
// Generic RAM: one write port, one read port with registered read data.
module bpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/buddy_page_allocator.sv */
// Buddy page allocator: per-order free bitmaps held in one single-bit RAM,
// walked by a sequencer that scans, splits, frees and merges one bit at a time.
// After reset and after every page_count write a clearing pass over all
// 2*NUM_PAGES bitmap bits rebuilds the bitmaps; no request is taken during it.
// An allocate scans bitmap bits (lowest index first, requested order upwards),
// then clears the found bit and splits it down to the requested order.
// A free marks the block's pages free one by one, merging each with its buddy
// level by level while the buddy is free. A bad order or out-of-range free
// is answered without touching the bitmaps. The single RAM port pair (one
// read, one write per cycle) paces all of these steps.
module buddy_page_allocator
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int ORDERS    = ORDERS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [PW-1:0] i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_action,
    input  logic [3:0]    i_order,
    input  logic [PW-1:0] i_page_number,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [SW-1:0] o_status,
    output logic [PW-1:0] o_block_page
);

    localparam int AW = $clog2(2 * NUM_PAGES);
    localparam int IW = $clog2(NUM_PAGES) + 1;
    localparam int KW = $clog2(ORDERS);
    localparam int JW = ORDERS;
    localparam logic [AW:0]   TWO_P = (AW+1)'(2 * NUM_PAGES);
    localparam logic [KW-1:0] TOP_K = KW'(ORDERS - 1);
    localparam logic [AW-1:0] LAST_CLR = AW'(2 * NUM_PAGES - 1);

    t_state        r_state, n_state;
    logic [KW-1:0] r_k, n_k;
    logic [KW-1:0] r_o, n_o;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_rel, n_rel;
    logic [JW-1:0] r_j, n_j;
    logic          r_dbl, n_dbl;
    logic [SW-1:0] r_status, n_status;
    logic [PW-1:0] r_block, n_block;
    logic [AW-1:0] r_clr, n_clr;
    logic [PW-1:0] r_base_page;
    logic [CW-1:0] r_page_count;
    logic          r_out_valid;
    logic [SW-1:0] r_out_status;
    logic [PW-1:0] r_out_block;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic          mem_rdata;

    logic [IW-1:0] pages_used;
    logic          in_take;
    logic          out_load;
    logic          cfg_pc;
    logic [IW-1:0] fp;
    logic [IW-1:0] buddy;
    logic [IW-1:0] parent;
    logic          last_page;
    logic          bad_order;
    logic [PW-1:0] diff;
    logic [PW:0]   span_end;
    logic          out_of_range;
    logic [AW:0]   clr_off;
    logic          clr_val;

    function automatic logic [AW-1:0] f_addr(input logic [KW-1:0] k, input logic [IW-1:0] i);
        logic [AW:0] a;
        a = TWO_P - (TWO_P >> k) + (AW+1)'(i);
        return a[AW-1:0];
    endfunction

    function automatic logic f_in(input logic [IW-1:0] pu, input logic [KW-1:0] k,
                                  input logic [IW-1:0] i);
        return i < (pu >> k);
    endfunction

    bpa_ram #(
        .WIDTH(1),
        .DEPTH(2 * NUM_PAGES)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign pages_used = (32'(r_page_count) > 32'(NUM_PAGES)) ? IW'(NUM_PAGES)
                                                               : IW'(r_page_count);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && (r_state == S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign cfg_pc     = i_cfg_we && (i_cfg_index == CFG_PAGE_COUNT);

    assign fp        = r_rel + IW'(r_j);
    assign buddy     = r_i ^ IW'(1);
    assign parent    = r_i >> 1;
    assign last_page = (r_j == ((JW'(1) << r_o) - JW'(1)));

    assign bad_order    = 32'(i_order) >= 32'(ORDERS);
    assign diff         = i_page_number - r_base_page;
    assign span_end     = {1'b0, diff} + ((PW+1)'(1) << i_order);
    assign out_of_range = (i_page_number < r_base_page) ||
                          (span_end > (PW+1)'(pages_used));

    assign clr_off = {1'b0, r_clr} - (TWO_P - (TWO_P >> TOP_K));
    assign clr_val = ({1'b0, r_clr} >= (TWO_P - (TWO_P >> TOP_K))) &&
                     (clr_off < (AW+1)'(pages_used >> TOP_K));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_CLR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    if (bad_order) begin
                        n_state = S_DONE;
                    end else if (i_action == ACT_ALLOC) begin
                        n_state = S_A_RD;
                    end else if (out_of_range) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_F_RD;
                    end
                end
            end
            S_A_RD: begin
                if (!f_in(pages_used, r_k, r_i)) begin
                    if (r_k == TOP_K) begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_A_CK;
                end
            end
            S_A_CK: n_state = mem_rdata ? S_A_CLR : S_A_RD;
            S_A_CLR: n_state = (r_k == r_o) ? S_DONE : S_A_SL;
            S_A_SL: n_state = S_A_SR;
            S_A_SR: n_state = (r_k == r_o) ? S_DONE : S_A_SL;
            S_F_RD: n_state = S_F_CK;
            S_F_CK: n_state = S_M_TEST;
            S_M_TEST: begin
                if (r_k == TOP_K || !f_in(pages_used, r_k, r_i) ||
                    !f_in(pages_used, r_k, buddy)) begin
                    n_state = last_page ? S_DONE : S_F_RD;
                end else begin
                    n_state = S_M_CK;
                end
            end
            S_M_CK: begin
                if (!mem_rdata) begin
                    n_state = last_page ? S_DONE : S_F_RD;
                end else begin
                    n_state = S_M_CLRB;
                end
            end
            S_M_CLRB: n_state = S_M_PAR;
            S_M_PAR: begin
                if (mem_rdata) begin
                    n_state = last_page ? S_DONE : S_F_RD;
                end else begin
                    n_state = S_M_TEST;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
        if (cfg_pc) begin
            n_state = S_CLEAR;
        end
    end

    always_comb begin
        n_k       = r_k;
        n_o       = r_o;
        n_i       = r_i;
        n_rel     = r_rel;
        n_j       = r_j;
        n_dbl     = r_dbl;
        n_status  = r_status;
        n_block   = r_block;
        n_clr     = r_clr;
        mem_we    = 1'b0;
        mem_waddr = f_addr(r_k, r_i);
        mem_wdata = 1'b0;
        mem_raddr = f_addr(r_k, r_i);
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = clr_val;
                n_clr     = r_clr + AW'(1);
            end
            S_IDLE: begin
                n_o      = KW'(i_order);
                n_k      = KW'(i_order);
                n_i      = '0;
                n_j      = '0;
                n_dbl    = 1'b0;
                n_rel    = IW'(diff);
                n_block  = '0;
                n_status = ST_OK;
                if (bad_order) begin
                    n_status = ST_BAD_ORDER;
                end else if (i_action == ACT_FREE && out_of_range) begin
                    n_status = ST_RANGE;
                end
            end
            S_A_RD: begin
                if (!f_in(pages_used, r_k, r_i)) begin
                    if (r_k == TOP_K) begin
                        n_status = ST_NO_SPACE;
                    end else begin
                        n_k = r_k + KW'(1);
                        n_i = '0;
                    end
                end
            end
            S_A_CK: begin
                if (!mem_rdata) begin
                    n_i = r_i + IW'(1);
                end
            end
            S_A_CLR: begin
                mem_we = 1'b1;
                if (r_k == r_o) begin
                    n_block = r_base_page + PW'(r_i << r_o);
                end else begin
                    n_k = r_k - KW'(1);
                    n_i = r_i << 1;
                end
            end
            S_A_SL: begin
                mem_we = 1'b1;
            end
            S_A_SR: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(r_k, r_i + IW'(1));
                mem_wdata = 1'b1;
                if (r_k == r_o) begin
                    n_block = r_base_page + PW'(r_i << r_o);
                end else begin
                    n_k = r_k - KW'(1);
                    n_i = r_i << 1;
                end
            end
            S_F_RD: begin
                mem_raddr = f_addr('0, fp);
            end
            S_F_CK: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr('0, fp);
                mem_wdata = 1'b1;
                if (mem_rdata) begin
                    n_dbl = 1'b1;
                end
                n_k = '0;
                n_i = fp;
            end
            S_M_TEST: begin
                mem_raddr = f_addr(r_k, buddy);
                if (r_k == TOP_K || !f_in(pages_used, r_k, r_i) ||
                    !f_in(pages_used, r_k, buddy)) begin
                    n_j      = r_j + JW'(1);
                    n_status = r_dbl ? ST_DBL_FREE : ST_OK;
                end
            end
            S_M_CK: begin
                if (!mem_rdata) begin
                    n_j      = r_j + JW'(1);
                    n_status = r_dbl ? ST_DBL_FREE : ST_OK;
                end else begin
                    mem_we = 1'b1;
                end
            end
            S_M_CLRB: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(r_k, buddy);
                mem_raddr = f_addr(r_k + KW'(1), parent);
            end
            S_M_PAR: begin
                if (mem_rdata) begin
                    n_j      = r_j + JW'(1);
                    n_status = r_dbl ? ST_DBL_FREE : ST_OK;
                end else begin
                    mem_we    = f_in(pages_used, r_k + KW'(1), parent);
                    mem_waddr = f_addr(r_k + KW'(1), parent);
                    mem_wdata = 1'b1;
                    n_k       = r_k + KW'(1);
                    n_i       = parent;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
        if (cfg_pc) begin
            n_clr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_base_page  <= '0;
            r_page_count <= PAGE_COUNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (i_cfg_we && i_cfg_index == CFG_BASE_PAGE) begin
                r_base_page <= i_cfg_data;
            end
            if (cfg_pc) begin
                r_page_count <= i_cfg_data[CW-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_o      <= n_o;
        r_i      <= n_i;
        r_rel    <= n_rel;
        r_j      <= n_j;
        r_dbl    <= n_dbl;
        r_status <= n_status;
        r_block  <= n_block;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_block  <= r_block;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_block_page = r_out_block;

endmodule
